[rtl/binomial_blur_3x3_unit_defines.svh]
// Assertion macros used by the checker of this block.
`ifndef BINOMIAL_BLUR_3X3_UNIT_DEFINES_SVH
`define BINOMIAL_BLUR_3X3_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BB3_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BB3_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bb3_pkg.sv]
package bb3_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int CHANNELS_DEF  = 3;

    localparam logic [12:0] LINE_WIDTH_RST   = 13'd640;
    localparam logic [15:0] FRAME_HEIGHT_RST = 16'd480;

    // register select, byte address bit 2
    localparam logic REG_LINE_WIDTH   = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_start;
    } pix_in_t;

    typedef struct packed {
        logic [7:0]  blur_red;
        logic [7:0]  blur_green;
        logic [7:0]  blur_blue;
        logic [11:0] center_col;
        logic [15:0] center_row;
        logic        interior;
    } pix_out_t;

endpackage

[rtl/bb3_line_store.sv]
module bb3_line_store #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 24
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_upper,
    input  logic [WIDTH-1:0]         wr_middle,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_upper,
    output logic [WIDTH-1:0]         rd_middle
);

    logic [WIDTH-1:0] upper_line_mem  [DEPTH];
    logic [WIDTH-1:0] middle_line_mem [DEPTH];
    logic [WIDTH-1:0] rd_upper_reg;
    logic [WIDTH-1:0] rd_middle_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            upper_line_mem[wr_addr]  <= wr_upper;
            middle_line_mem[wr_addr] <= wr_middle;
        end
    end

    // write-first on an address collision
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_upper_reg  <= wr_upper;
                rd_middle_reg <= wr_middle;
            end else begin
                rd_upper_reg  <= upper_line_mem[rd_addr];
                rd_middle_reg <= middle_line_mem[rd_addr];
            end
        end
    end

    assign rd_upper  = rd_upper_reg;
    assign rd_middle = rd_middle_reg;

endmodule

[rtl/bb3_lane.sv]
module bb3_lane (
    input  logic [8:0][7:0] taps_i,
    output logic [7:0]      sum_o
);

    // taps_i[r*3+k]: r row top..bottom, k column left..right
    logic [7:0] corners;
    logic [7:0] edges;
    logic [7:0] centre;

    always_comb begin
        corners = 8'(taps_i[0][7:4]) + 8'(taps_i[2][7:4])
                + 8'(taps_i[6][7:4]) + 8'(taps_i[8][7:4]);
        edges   = 8'(taps_i[1][7:3]) + 8'(taps_i[3][7:3])
                + 8'(taps_i[5][7:3]) + 8'(taps_i[7][7:3]);
        centre  = 8'(taps_i[4][7:2]);
        sum_o   = corners + edges + centre;
    end

endmodule

[rtl/binomial_blur_3x3_unit.sv]
// Channel  Dir  Handshake          Beat
// s_       in   s_valid / s_ready  one RGB pixel, raster order (pix_in_t)
// m_       out  m_valid / m_ready  one filtered centre pixel (pix_out_t)
// apb      in   psel / penable     line_width at 0x0, frame_height at 0x4
//
// Throughput is one pixel per cycle while m_ is not stalled; the line
// store has one read and one write port, used once per pixel. A result
// passes through the input stage and the output register. After reset a
// clearing pass zeroes all line store addresses with s_ready low. A stall
// on m_ is held in the output register; after clearing, the input stalls
// only when that register and the input stage are both full.
module binomial_blur_3x3_unit #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF,
    parameter int CHANNELS  = bb3_pkg::CHANNELS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bb3_pkg::pix_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bb3_pkg::pix_out_t m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    import bb3_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int PW = 8 * CHANNELS;

    function automatic logic [7:0] chan_of(input pix_in_t p, input int c);
        logic [7:0] v;
        case (c)
            0:       v = p.red;
            1:       v = p.green;
            2:       v = p.blue;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    // configuration
    logic [12:0] line_width_reg;
    logic [15:0] frame_height_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= LINE_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_LINE_WIDTH) begin
                line_width_reg <= pwdata[12:0];
            end else begin
                frame_height_reg <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_LINE_WIDTH) ? {19'd0, line_width_reg}
                                                 : {16'd0, frame_height_reg};

    logic [XW:0] eff_width;
    logic [15:0] eff_height;

    always_comb begin
        if ({1'b0, line_width_reg} > 14'(MAX_WIDTH)) begin
            eff_width = (XW+1)'(MAX_WIDTH);
        end else if (line_width_reg < 13'd3) begin
            eff_width = (XW+1)'(3);
        end else begin
            eff_width = (XW+1)'(line_width_reg);
        end
        eff_height = (frame_height_reg < 16'd3) ? 16'd3 : frame_height_reg;
    end

    // line store clearing pass
    logic          clr_active_reg, clr_active_next;
    logic [XW-1:0] clr_addr_reg, clr_addr_next;

    always_comb begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == XW'(MAX_WIDTH - 1)) begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    // input stage: position and line store read
    logic          s_fire, adv1;
    logic          valid1_reg, valid1_next;
    logic [XW-1:0] col_reg, col_next;
    logic [15:0]   row_reg, row_next;
    logic [XW-1:0] x0;
    logic [15:0]   y0;
    logic [XW:0]   x0_inc;
    logic [16:0]   y0_inc;
    logic [PW-1:0] px0;
    logic [XW-1:0] x1_reg;
    logic [15:0]   y1_reg;
    logic [PW-1:0] px1_reg;

    assign s_ready = !clr_active_reg && (!valid1_reg || adv1);
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        x0     = s_data.frame_start ? '0 : col_reg;
        y0     = s_data.frame_start ? '0 : row_reg;
        x0_inc = {1'b0, x0} + (XW+1)'(1);
        y0_inc = {1'b0, y0} + 17'd1;
        col_next = col_reg;
        row_next = row_reg;
        if (s_fire) begin
            if (x0_inc >= eff_width) begin
                col_next = '0;
                row_next = (y0_inc >= {1'b0, eff_height}) ? 16'd0 : y0_inc[15:0];
            end else begin
                col_next = x0_inc[XW-1:0];
                row_next = y0;
            end
        end
        px0 = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            px0[8*c +: 8] = chan_of(s_data, c);
        end
    end

    always_comb begin
        valid1_next = valid1_reg;
        if (s_fire) begin
            valid1_next = 1'b1;
        end else if (adv1) begin
            valid1_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            valid1_reg <= 1'b0;
        end else begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            valid1_reg <= valid1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            x1_reg  <= x0;
            y1_reg  <= y0;
            px1_reg <= px0;
        end
    end

    // line store
    logic          ls_wr_en;
    logic [XW-1:0] ls_wr_addr;
    logic [PW-1:0] ls_wr_upper, ls_wr_middle;
    logic [PW-1:0] top_q, mid_q;

    assign ls_wr_en     = clr_active_reg || adv1;
    assign ls_wr_addr   = clr_active_reg ? clr_addr_reg : x1_reg;
    assign ls_wr_upper  = clr_active_reg ? '0 : mid_q;
    assign ls_wr_middle = clr_active_reg ? '0 : px1_reg;

    bb3_line_store #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (PW)
    ) u_line_store (
        .aclk      (aclk),
        .wr_en     (ls_wr_en),
        .wr_addr   (ls_wr_addr),
        .wr_upper  (ls_wr_upper),
        .wr_middle (ls_wr_middle),
        .rd_en     (s_fire),
        .rd_addr   (x0),
        .rd_upper  (top_q),
        .rd_middle (mid_q)
    );

    // window stage: columns x-1 (col1) and x-2 (col2), rows top..bottom
    logic [2:0][PW-1:0] col1_reg, col2_reg;

    always_ff @(posedge aclk) begin
        if (adv1) begin
            col2_reg <= col1_reg;
            col1_reg <= {px1_reg, mid_q, top_q};
        end
    end

    logic [CHANNELS-1:0][7:0] lane_sum;
    logic [3:0][7:0]          lane_pad;

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        bb3_lane u_lane (
            .taps_i ({px1_reg[8*c +: 8],     col1_reg[2][8*c +: 8], col2_reg[2][8*c +: 8],
                      mid_q[8*c +: 8],       col1_reg[1][8*c +: 8], col2_reg[1][8*c +: 8],
                      top_q[8*c +: 8],       col1_reg[0][8*c +: 8], col2_reg[0][8*c +: 8]}),
            .sum_o  (lane_sum[c])
        );
    end

    // merge and output register
    logic          emit1, inside1;
    logic [XW-1:0] cx1;
    logic [15:0]   cy1;
    logic          m_valid_reg, m_valid_next;
    pix_out_t      m_data_reg, m_data_next;

    assign adv1 = valid1_reg && (!m_valid_reg || m_ready);

    always_comb begin
        lane_pad = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            lane_pad[c] = lane_sum[c];
        end
        emit1   = (x1_reg != '0) && (y1_reg != 16'd0);
        cx1     = x1_reg - 1'b1;
        cy1     = y1_reg - 16'd1;
        inside1 = (cx1 != '0) && (cy1 != 16'd0);

        m_data_next.blur_red   = inside1 ? lane_pad[0] : 8'd0;
        m_data_next.blur_green = inside1 ? lane_pad[1] : 8'd0;
        m_data_next.blur_blue  = inside1 ? lane_pad[2] : 8'd0;
        m_data_next.center_col = 12'(cx1);
        m_data_next.center_row = cy1;
        m_data_next.interior   = inside1;

        m_valid_next = m_valid_reg;
        if (adv1) begin
            m_valid_next = emit1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && emit1) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/bb3_checker.sv]
`include "binomial_blur_3x3_unit_defines.svh"

module bb3_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input bb3_pkg::pix_out_t m_data
);

    `BB3_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result beat changed while stalled")

    `BB3_ASSERT_NOW(a_border_zero, aclk, aresetn, m_valid && !m_data.interior, m_data.blur_red == 8'd0 && m_data.blur_green == 8'd0 && m_data.blur_blue == 8'd0, "border center with nonzero blur")

    `BB3_ASSERT_NOW(a_interior_pos, aclk, aresetn, m_valid && m_data.interior, m_data.center_col != 12'd0 && m_data.center_row != 16'd0, "interior flag on a border center")

endmodule

bind binomial_blur_3x3_unit bb3_checker u_bb3_checker (.*);

[verif/binomial_blur_3x3_unit_tb.sv]
module binomial_blur_3x3_unit_tb;
    import bb3_pkg::*;

    localparam int MAX_W       = MAX_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 8;

    typedef logic [2:0][7:0] rgb_t;    // [0] red, [1] green, [2] blue

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    pix_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    pix_out_t    m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    binomial_blur_3x3_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // filter state mirror
    logic [12:0] width_reg;
    logic [15:0] height_reg;
    rgb_t        row_above [MAX_W];
    rgb_t        row_prev  [MAX_W];
    rgb_t        win_near  [3];
    rgb_t        win_far   [3];
    int unsigned col_pos;
    int unsigned row_pos;

    pix_out_t    pending_blur [$];

    int          err_cnt;
    int          pixel_cnt;
    int          blur_cnt;
    int          interior_cnt;
    int          reg_wr_cnt;
    int          cycle_cnt;
    bit          src_idle;
    bit          sink_idle;
    int          sink_hold;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_blur.size());
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    function automatic pix_in_t rand_pixel(bit fs);
        pix_in_t p;
        p.red         = 8'($urandom());
        p.green       = 8'($urandom());
        p.blue        = 8'($urandom());
        p.frame_start = fs;
        return p;
    endfunction

    // advance the window and line stores by one pixel, queue the centre result if any
    function automatic void filter_pixel(pix_in_t p);
        rgb_t        px;
        rgb_t        above;
        rgb_t        prev;
        int unsigned x;
        int unsigned y;
        int unsigned eff_w;
        int unsigned eff_h;
        int unsigned acc [3];
        pix_out_t    r;
        bit          is_int;
        if (p.frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        x     = col_pos % MAX_W;
        y     = row_pos;
        px    = {p.blue, p.green, p.red};
        above = row_above[x];
        prev  = row_prev[x];
        if (x >= 1 && y >= 1) begin
            is_int = (x != 1) && (y != 1);
            for (int c = 0; c < 3; c++) begin
                acc[c] = 0;
                if (is_int)
                    acc[c] = win_far[0][c] / 16 + win_near[0][c] / 8 + above[c] / 16
                           + win_far[1][c] / 8  + win_near[1][c] / 4 + prev[c] / 8
                           + win_far[2][c] / 16 + win_near[2][c] / 8 + px[c] / 16;
            end
            r.blur_red   = 8'(acc[0]);
            r.blur_green = 8'(acc[1]);
            r.blur_blue  = 8'(acc[2]);
            r.center_col = 12'(x - 1);
            r.center_row = 16'(y - 1);
            r.interior   = is_int;
            pending_blur.push_back(r);
        end
        win_far     = win_near;
        win_near[0] = above;
        win_near[1] = prev;
        win_near[2] = px;
        row_above[x] = prev;
        row_prev[x]  = px;
        eff_w = (width_reg < 3) ? 3 : ((width_reg > MAX_W) ? MAX_W : width_reg);
        eff_h = (height_reg < 3) ? 3 : height_reg;
        if (x + 1 >= eff_w) begin
            col_pos = 0;
            row_pos = (y + 1 >= eff_h) ? 0 : y + 1;
        end else begin
            col_pos = x + 1;
            row_pos = y;
        end
    endfunction

    task automatic send_pixel(input pix_in_t p);
        int gap;
        gap = src_idle ? $urandom_range(0, 4) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
        filter_pixel(p);
        pixel_cnt++;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_blur.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic apb_cycle(input logic wr, input logic [2:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(input logic sel);
        logic [31:0] rd;
        apb_cycle(1'b0, {sel, 2'b00}, '0, rd);
        if (sel == REG_LINE_WIDTH)
            check_field("line_width", width_reg, rd);
        else
            check_field("frame_height", height_reg, rd);
    endtask

    task automatic write_reg(input logic sel, input logic [31:0] value);
        logic [31:0] rd;
        apb_cycle(1'b1, {sel, 2'b00}, value, rd);
        if (sel == REG_LINE_WIDTH)
            width_reg = value[12:0];
        else
            height_reg = value[15:0];
        reg_wr_cnt++;
        check_reg(sel);
    endtask

    initial begin : result_sink
        int gap;
        m_ready = 1'b0;
        forever begin
            gap = sink_idle ? $urandom_range(0, 4) : 0;
            if (sink_hold > 0) begin
                gap       = sink_hold;
                sink_hold = 0;
            end
            @(negedge aclk);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_blur.size() == 0) begin
                $error("result beat with nothing expected: col %0d row %0d",
                       m_data.center_col, m_data.center_row);
                err_cnt++;
            end else begin
                pix_out_t e;
                e = pending_blur.pop_front();
                check_field("blur_red",   e.blur_red,   m_data.blur_red);
                check_field("blur_green", e.blur_green, m_data.blur_green);
                check_field("blur_blue",  e.blur_blue,  m_data.blur_blue);
                check_field("center_col", e.center_col, m_data.center_col);
                check_field("center_row", e.center_row, m_data.center_row);
                check_field("interior",   e.interior,   m_data.interior);
            end
            blur_cnt++;
            if (m_data.interior)
                interior_cnt++;
        end
    end

    task automatic test_reset_values();
        check_reg(REG_LINE_WIDTH);
        check_reg(REG_FRAME_HEIGHT);
    endtask

    // 3x3 frames: saturated white, black after wrap with clamped registers,
    // then a frame restarted part way through
    task automatic test_directed_frames();
        pix_in_t p;
        write_reg(REG_LINE_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 3);
        for (int i = 0; i < 9; i++) begin
            p = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF, frame_start: (i == 0)};
            send_pixel(p);
        end
        wait_idle();
        write_reg(REG_LINE_WIDTH, 1);
        write_reg(REG_FRAME_HEIGHT, 0);
        for (int i = 0; i < 9; i++) begin
            p = '{red: 8'h00, green: 8'h00, blue: 8'h00, frame_start: 1'b0};
            send_pixel(p);
        end
        wait_idle();
        write_reg(REG_LINE_WIDTH, 2);
        write_reg(REG_FRAME_HEIGHT, 2);
        for (int i = 0; i < 13; i++) begin
            p = rand_pixel(i == 4);
            if (i == 7)
                p = '{red: 8'hFF, green: 8'h00, blue: 8'h80, frame_start: 1'b0};
            send_pixel(p);
        end
        wait_idle();
    endtask

    // receiver holds off while pixels stream at full rate
    task automatic test_output_stall();
        write_reg(REG_LINE_WIDTH, 16);
        write_reg(REG_FRAME_HEIGHT, 6);
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        sink_hold = 200;
        for (int i = 0; i < 96; i++)
            send_pixel(rand_pixel(i == 0));
        wait_idle();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    task automatic test_random_frames();
        int          budget;
        int          n_pix;
        logic [12:0] w;
        logic [15:0] h;
        bit          fs;
        budget = 1180;
        while (budget > 0) begin
            case ($urandom_range(0, 7))
                0:       w = 13'($urandom_range(0, 2));
                1:       w = 13'($urandom_range(21, 64));
                default: w = 13'($urandom_range(3, 20));
            endcase
            case ($urandom_range(0, 7))
                0:       h = 16'($urandom_range(0, 2));
                1:       h = 16'hFFFF;
                2:       h = 16'($urandom());
                default: h = 16'($urandom_range(3, 8));
            endcase
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            write_reg(REG_LINE_WIDTH, 32'(w));
            write_reg(REG_FRAME_HEIGHT, 32'(h));
            n_pix = $urandom_range(40, 160);
            for (int i = 0; i < n_pix; i++) begin
                // mostly clean frames; stray frame starts as noise
                fs = (i == 0 && $urandom_range(0, 3) != 0) || ($urandom_range(0, 49) == 0);
                send_pixel(rand_pixel(fs));
            end
            wait_idle();
            budget -= n_pix;
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    // over-range width clamps to the full line store; a narrower width
    // set part way through the row wraps the column after the next pixel
    task automatic test_widest_line();
        write_reg(REG_LINE_WIDTH, 32'h1FFF);
        write_reg(REG_FRAME_HEIGHT, 3);
        for (int i = 0; i < 60; i++)
            send_pixel(rand_pixel(i == 0));
        wait_idle();
        write_reg(REG_LINE_WIDTH, 4);
        for (int i = 0; i < 20; i++)
            send_pixel(rand_pixel(1'b0));
        wait_idle();
    endtask

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        width_reg  = LINE_WIDTH_RST;
        height_reg = FRAME_HEIGHT_RST;
        col_pos    = 0;
        row_pos    = 0;
        for (int i = 0; i < MAX_W; i++) begin
            row_above[i] = '0;
            row_prev[i]  = '0;
        end
        for (int i = 0; i < 3; i++) begin
            win_near[i] = '0;
            win_far[i]  = '0;
        end
        err_cnt      = 0;
        pixel_cnt    = 0;
        blur_cnt     = 0;
        interior_cnt = 0;
        reg_wr_cnt   = 0;
        cycle_cnt    = 0;
        src_idle     = 1'b1;
        sink_idle    = 1'b1;
        sink_hold    = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_directed_frames();
        test_output_stall();
        test_random_frames();
        test_widest_line();

        $display("Sent %0d pixels, checked %0d results (%0d interior), %0d register writes",
                 pixel_cnt, blur_cnt, interior_cnt, reg_wr_cnt);
        $display("Widths 3..4096 incl. clamped values, heights 0..65535, output stall tested");
        if (err_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/bb3_pkg.sv
rtl/bb3_line_store.sv
rtl/bb3_lane.sv
rtl/binomial_blur_3x3_unit.sv
rtl/bb3_checker.sv
verif/binomial_blur_3x3_unit_tb.sv
